// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== hw/rtl/dmm_pkg.sv =====
// types and constants of the dense matrix multiply block
package dmm_pkg;

   localparam int IDX_W = 3;
   localparam int DIM_W = 4;
   localparam int VAL_W = 16;
   localparam int RES_W = 40;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   // one multiply-accumulate step from the controller
   typedef struct packed {
      logic             valid;
      logic             first_k;
      logic             last_k;
      logic             last_entry;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] k;
   } dmm_cmd_type;

endpackage

// ===== hw/rtl/dmm_ram.sv =====
// generic single write port, single read port ram with registered read
module dmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dmm_ctrl.sv =====
// controller: dimension registers and the row, column, inner loop sequencer
module dmm_ctrl import dmm_pkg::*; #(
   parameter int MAX_DIM = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_start_req,
   output logic                 busy,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data,
   input  logic                 pipe_idle,
   output dmm_cmd_type          cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [DIM_W-1:0] rows_a_ff, rows_a_in;
   logic [DIM_W-1:0] inner_dim_ff, inner_dim_in;
   logic [DIM_W-1:0] cols_b_ff, cols_b_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] last_row, last_col, last_k;
   logic             csr_wr;
   logic             k_wrap, col_wrap, row_wrap;

   // highest loop index: zero acts as one, too large acts as MAX_DIM
   function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] c;
      if (d == '0) begin
         c = '0;
      end else if (d > DIM_W'(MAX_DIM)) begin
         c = DIM_W'(MAX_DIM - 1);
      end else begin
         c = d - 1'b1;
      end
      return c[IDX_W-1:0];
   endfunction

   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = !busy;
   assign csr_wr = csr_valid && csr_ready;

   assign last_row = dim_last(rows_a_ff);
   assign last_k = dim_last(inner_dim_ff);
   assign last_col = dim_last(cols_b_ff);

   assign k_wrap = (k_ff == last_k);
   assign col_wrap = k_wrap && (col_ff == last_col);
   assign row_wrap = col_wrap && (row_ff == last_row);

   always_comb begin
      rows_a_in = rows_a_ff;
      inner_dim_in = inner_dim_ff;
      cols_b_in = cols_b_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_ROWS_A: begin
               rows_a_in = csr_data;
            end
            CSR_INNER_DIM: begin
               inner_dim_in = csr_data;
            end
            CSR_COLS_B: begin
               cols_b_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      col_in = col_ff;
      k_in = k_ff;
      case (state_ff)
         ST_IDLE: begin
            row_in = '0;
            col_in = '0;
            k_in = '0;
            if (start && req_start_req) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            k_in = k_wrap ? '0 : k_ff + 1'b1;
            if (k_wrap) begin
               col_in = (col_ff == last_col) ? '0 : col_ff + 1'b1;
            end
            if (col_wrap) begin
               row_in = row_ff + 1'b1;
            end
            if (row_wrap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_idle) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.valid = (state_ff == ST_ISSUE);
      cmd.first_k = (k_ff == '0);
      cmd.last_k = k_wrap;
      cmd.last_entry = row_wrap;
      cmd.row = row_ff;
      cmd.col = col_ff;
      cmd.k = k_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_a_ff <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_b_ff <= DIM_RESET;
         row_ff <= '0;
         col_ff <= '0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         rows_a_ff <= rows_a_in;
         inner_dim_ff <= inner_dim_in;
         cols_b_ff <= cols_b_in;
         row_ff <= row_in;
         col_ff <= col_in;
         k_ff <= k_in;
      end
   end

endmodule

// ===== hw/rtl/dmm_datapath.sv =====
// datapath: element stores, multiplier, accumulator and result register
module dmm_datapath import dmm_pkg::*; #(
   parameter int MAX_DIM = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_en,
   input  logic                    req_which_matrix,
   input  logic [IDX_W-1:0]        req_row_index,
   input  logic [IDX_W-1:0]        req_col_index,
   input  logic signed [VAL_W-1:0] req_element_value,
   input  dmm_cmd_type             cmd,
   output logic                    pipe_idle,
   output logic                    rsp_valid,
   output logic [IDX_W-1:0]        rsp_result_row,
   output logic [IDX_W-1:0]        rsp_result_col,
   output logic signed [RES_W-1:0] rsp_result_value,
   output logic                    rsp_last
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LOAD_W = (ELEM_WIDTH < VAL_W) ? ELEM_WIDTH : VAL_W;
   localparam int PROD_W = 2 * ELEM_WIDTH;
   localparam int ADDR_CALC_W = 2 * IDX_W + 1;

   logic [ELEM_WIDTH-1:0]      elem;
   logic                       in_range;
   logic [AW-1:0]              wr_addr, a_rd_addr, b_rd_addr;
   logic [ELEM_WIDTH-1:0]      a_rd, b_rd;
   dmm_cmd_type                s1_ff, s2_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [RES_W-1:0]    acc_ff, acc_sum;
   logic                       rsp_valid_ff;
   logic [IDX_W-1:0]           rsp_row_ff, rsp_col_ff;
   logic signed [RES_W-1:0]    rsp_value_ff;
   logic                       rsp_last_ff;

   function automatic logic [AW-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                               input logic [IDX_W-1:0] c);
      logic [ADDR_CALC_W-1:0] a;
      a = ADDR_CALC_W'(r) * ADDR_CALC_W'(MAX_DIM) + ADDR_CALC_W'(c);
      return a[AW-1:0];
   endfunction

   // low bits of the word, sign-extended to the element width
   assign elem = ELEM_WIDTH'($signed(req_element_value[LOAD_W-1:0]));
   assign in_range = (IDX_W'(0) == '0) &&
                     ({1'b0, req_row_index} < (IDX_W + 1)'(MAX_DIM)) &&
                     ({1'b0, req_col_index} < (IDX_W + 1)'(MAX_DIM));
   assign wr_addr = elem_addr(req_row_index, req_col_index);
   assign a_rd_addr = elem_addr(cmd.row, cmd.k);
   assign b_rd_addr = elem_addr(cmd.k, cmd.col);

   dmm_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (load_en && in_range && !req_which_matrix),
      .wr_addr (wr_addr),
      .wr_data (elem),
      .rd_en   (cmd.valid),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd)
   );

   dmm_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (load_en && in_range && req_which_matrix),
      .wr_addr (wr_addr),
      .wr_data (elem),
      .rd_en   (cmd.valid),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd)
   );

   assign prod_in = $signed(a_rd) * $signed(b_rd);
   // sums wrap at the accumulator width
   assign acc_sum = (s2_ff.first_k ? RES_W'(0) : acc_ff) + RES_W'(prod_ff);

   assign pipe_idle = !s1_ff.valid && !s2_ff.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff <= cmd;
         s2_ff <= s1_ff;
         rsp_valid_ff <= s2_ff.valid && s2_ff.last_k;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (s2_ff.valid) begin
         acc_ff <= acc_sum;
      end
      if (s2_ff.valid && s2_ff.last_k) begin
         rsp_row_ff <= s2_ff.row;
         rsp_col_ff <= s2_ff.col;
         rsp_value_ff <= acc_sum;
         rsp_last_ff <= s2_ff.last_entry;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_row = rsp_row_ff;
   assign rsp_result_col = rsp_col_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_last = rsp_last_ff;

endmodule

// ===== hw/rtl/dense_matrix_multiply_top.sv =====
// top level of the dense matrix multiply block
// Element loads are accepted back to back while busy is low. An item
// with req_start_req set writes its element and then holds busy high for
// rows_a * inner_dim * cols_b multiply-accumulates (dimensions after
// clamping to 1..MAX_DIM), one per cycle through the single read port of
// each store, and until the read, multiply and accumulate steps drain.
// Each entry of C leaves on rsp_valid after inner_dim products, row-major, with
// rsp_last on the final one. Results are shown for one cycle and cannot be
// stalled. Configuration words are taken only while busy is low. Store
// entries hold no defined value until they are written.
`include "assert_macros.svh"

module dense_matrix_multiply_top import dmm_pkg::*; #(
   parameter int MAX_DIM = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_which_matrix,
   input  logic [IDX_W-1:0]        req_row_index,
   input  logic [IDX_W-1:0]        req_col_index,
   input  logic signed [VAL_W-1:0] req_element_value,
   input  logic                    req_start_req,
   output logic                    rsp_valid,
   output logic [IDX_W-1:0]        rsp_result_row,
   output logic [IDX_W-1:0]        rsp_result_col,
   output logic signed [RES_W-1:0] rsp_result_value,
   output logic                    rsp_last,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [DIM_W-1:0]        csr_data
);

   dmm_cmd_type cmd;
   logic        pipe_idle;
   logic        load_en;

   assign load_en = start && !busy;

   dmm_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (load_en),
      .req_start_req (req_start_req),
      .busy          (busy),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .pipe_idle     (pipe_idle),
      .cmd           (cmd)
   );

   dmm_datapath #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .load_en           (load_en),
      .req_which_matrix  (req_which_matrix),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .cmd               (cmd),
      .pipe_idle         (pipe_idle),
      .rsp_valid         (rsp_valid),
      .rsp_result_row    (rsp_result_row),
      .rsp_result_col    (rsp_result_col),
      .rsp_result_value  (rsp_result_value),
      .rsp_last          (rsp_last)
   );

   // a result word only appears during a multiply run
   `ASSERT_NEVER(a_rsp_only_busy, clock, reset, rsp_valid && !busy)
   // the final word ends the run
   `ASSERT_PROP(a_last_ends_run, clock, reset, rsp_valid && rsp_last |=> !busy && !rsp_valid)
   // a plain load never starts a run
   `ASSERT_PROP(a_load_stays_idle, clock, reset, start && !busy && !req_start_req |=> !busy)
   // no issue left over once idle
   `ASSERT_NEVER(a_idle_no_cmd, clock, reset, !busy && cmd.valid)

endmodule

// ===== tb/sv/tb_dense_matrix_multiply_top.sv =====
// testbench of the dense matrix multiply top: loads both stores, runs products, checks every entry
module tb_dense_matrix_multiply_top import dmm_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM = 8;
   localparam int STALL_LIMIT = 3000;
   localparam int RANDOM_ITEMS = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [RES_W-1:0] value;
      logic                    last;
   } product_entry_type;

   class product_scoreboard;
      logic signed [VAL_W-1:0] a_mem [MAX_DIM*MAX_DIM];
      logic signed [VAL_W-1:0] b_mem [MAX_DIM*MAX_DIM];
      logic [DIM_W-1:0]        rows_a;
      logic [DIM_W-1:0]        inner_dim;
      logic [DIM_W-1:0]        cols_b;
      product_entry_type       pending_entries [$];
      int                      mismatch_count;

      function new();
         rows_a = DIM_RESET;
         inner_dim = DIM_RESET;
         cols_b = DIM_RESET;
         mismatch_count = 0;
         foreach (a_mem[i]) begin
            a_mem[i] = '0;
            b_mem[i] = '0;
         end
      endfunction

      function void set_dim(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
         case (idx)
            CSR_ROWS_A: begin
               rows_a = data;
            end
            CSR_INNER_DIM: begin
               inner_dim = data;
            end
            CSR_COLS_B: begin
               cols_b = data;
            end
            default: begin
            end
         endcase
      endfunction

      // zero acts as one, anything above the store size acts as the store size
      function int eff_dim(logic [DIM_W-1:0] d);
         if (d == 0) return 1;
         if (d > MAX_DIM) return MAX_DIM;
         return int'(d);
      endfunction

      function void note_item(logic which, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                              logic signed [VAL_W-1:0] value, logic go);
         int nr;
         int nk;
         int nc;
         int i;
         int j;
         int k;
         logic signed [RES_W-1:0] acc;
         product_entry_type entry;
         if (which) b_mem[row*MAX_DIM+col] = value;
         else a_mem[row*MAX_DIM+col] = value;
         if (!go) return;
         nr = eff_dim(rows_a);
         nk = eff_dim(inner_dim);
         nc = eff_dim(cols_b);
         for (i = 0; i < nr; i++) begin
            for (j = 0; j < nc; j++) begin
               acc = '0;
               // all operands signed, so products are widened to the accumulator
               for (k = 0; k < nk; k++) acc = acc + a_mem[i*MAX_DIM+k] * b_mem[k*MAX_DIM+j];
               entry.row = IDX_W'(i);
               entry.col = IDX_W'(j);
               entry.value = acc;
               entry.last = (i == nr - 1) && (j == nc - 1);
               pending_entries.push_back(entry);
            end
         end
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         mismatch_count++;
      endtask

      task check_result(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                        logic signed [RES_W-1:0] value, logic last);
         product_entry_type entry;
         if (pending_entries.size() == 0) begin
            report_mismatch($sformatf("unexpected entry row %0d col %0d value %0d",
                                      row, col, value));
            return;
         end
         entry = pending_entries.pop_front();
         if (row !== entry.row)
            report_mismatch($sformatf("row %0d, want %0d", row, entry.row));
         if (col !== entry.col)
            report_mismatch($sformatf("col %0d, want %0d", col, entry.col));
         if (value !== entry.value)
            report_mismatch($sformatf("value %0d at (%0d,%0d), want %0d",
                                      value, entry.row, entry.col, entry.value));
         if (last !== entry.last)
            report_mismatch($sformatf("last %0b at (%0d,%0d), want %0b",
                                      last, entry.row, entry.col, entry.last));
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_which_matrix;
   logic [IDX_W-1:0]        req_row_index;
   logic [IDX_W-1:0]        req_col_index;
   logic signed [VAL_W-1:0] req_element_value;
   logic                    req_start_req;
   logic                    rsp_valid;
   logic [IDX_W-1:0]        rsp_result_row;
   logic [IDX_W-1:0]        rsp_result_col;
   logic signed [RES_W-1:0] rsp_result_value;
   logic                    rsp_last;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [DIM_W-1:0]        csr_data;

   product_scoreboard sb;
   int  items_sent;
   bit  no_idle;
   int  stall_cycles = 0;

   dense_matrix_multiply_top u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_which_matrix  (req_which_matrix),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .req_start_req     (req_start_req),
      .rsp_valid         (rsp_valid),
      .rsp_result_row    (rsp_result_row),
      .rsp_result_col    (rsp_result_col),
      .rsp_result_value  (rsp_result_value),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_result_row, rsp_result_col, rsp_result_value, rsp_last);
   end

   // any word moved on any channel counts as progress
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("no progress for %0d cycles", stall_cycles);
         $display("dense_matrix_multiply_top test failed");
         $finish;
      end
   end

   function automatic int idle_len();
      int n;
      n = 0;
      if (no_idle) return 0;
      while (n < 12 && $urandom_range(99) < 36) n++;
      return n;
   endfunction

   task automatic send_item(logic which, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                            logic [VAL_W-1:0] value, logic go);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_which_matrix <= which;
      req_row_index <= row;
      req_col_index <= col;
      req_element_value <= value;
      req_start_req <= go;
      do @(posedge clock); while (busy);
      sb.note_item(which, row, col, value, go);
      items_sent++;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_dim(idx, data);
   endtask

   task automatic configure(logic [DIM_W-1:0] ra, logic [DIM_W-1:0] ki, logic [DIM_W-1:0] cb,
                            bit poke_unused);
      write_csr(CSR_ROWS_A, ra);
      write_csr(CSR_INNER_DIM, ki);
      write_csr(CSR_COLS_B, cb);
      if (poke_unused) write_csr(CSR_UNUSED, DIM_W'($urandom_range(15)));
      csr_valid <= 1'b0;
   endtask

   // drop start, drain all entries, then give the pipeline time to empty
   task automatic settle();
      start <= 1'b0;
      while (sb.pending_entries.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [DIM_W-1:0] pick_dim();
      int r;
      r = $urandom_range(99);
      if (r < 8) return '0;
      if (r < 16) return DIM_W'($urandom_range(15, 9));
      if (r < 24) return DIM_W'(MAX_DIM);
      return DIM_W'($urandom_range(4, 1));
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(19))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   initial begin
      int k;
      int n;
      int target;
      sb = new();
      items_sent = 0;
      no_idle = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_which_matrix <= 1'b0;
      req_row_index <= '0;
      req_col_index <= '0;
      req_element_value <= '0;
      req_start_req <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every entry written once so no product ever reads an unwritten word
      for (k = 0; k < 2 * MAX_DIM * MAX_DIM; k++) begin
         // back-to-back loads through the middle of the fill
         no_idle = (k >= MAX_DIM * MAX_DIM / 2) && (k < 3 * MAX_DIM * MAX_DIM / 2);
         send_item(1'(k / (MAX_DIM*MAX_DIM)), IDX_W'(k / MAX_DIM), IDX_W'(k), pick_value(),
                   1'b0);
      end
      no_idle = 0;

      // reset dimensions, full 8x8x8 product
      send_item(1'b0, 3'd0, 3'd0, 16'h7FFF, 1'b1);
      settle();
      configure(4'd1, 4'd1, 4'd1, 1'b0);
      send_item(1'b1, 3'd0, 3'd0, 16'h8000, 1'b1);
      settle();
      // zero dimensions act as one, the spare register index is ignored
      configure(4'd0, 4'd0, 4'd0, 1'b1);
      send_item(1'b0, 3'd7, 3'd7, 16'h8000, 1'b0);
      send_item(1'b1, 3'd0, 3'd0, 16'h7FFF, 1'b1);
      settle();
      // largest positive sum: eight products of the most negative element
      configure(4'd1, 4'd8, 4'd1, 1'b0);
      for (k = 0; k < MAX_DIM; k++) send_item(1'b0, 3'd0, IDX_W'(k), 16'h8000, 1'b0);
      for (k = 0; k < MAX_DIM; k++)
         send_item(1'b1, IDX_W'(k), 3'd0, 16'h8000, k == MAX_DIM - 1);
      settle();
      // oversize dimensions act as the store size
      configure(4'd15, 4'd15, 4'd15, 1'b0);
      send_item(1'b1, 3'd3, 3'd5, 16'h7FFF, 1'b1);
      settle();

      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         configure(pick_dim(), pick_dim(), pick_dim(), $urandom_range(3) == 0);
         n = $urandom_range(6, 2);
         for (k = 0; k < n; k++)
            send_item(1'($urandom_range(1)), IDX_W'($urandom), IDX_W'($urandom), pick_value(),
                      $urandom_range(5) == 0 || (k == n - 1 && $urandom_range(1)));
         settle();
      end
      no_idle = 0;

      while (sb.pending_entries.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.pending_entries.size() != 0)
         sb.report_mismatch($sformatf("%0d entries never arrived", sb.pending_entries.size()));
      if (sb.mismatch_count == 0) begin
         $display("dense_matrix_multiply_top test passed");
      end else begin
         $display("dense_matrix_multiply_top test failed");
      end
      $finish;
   end

endmodule

// ===== dense_matrix_multiply_top.f =====
+incdir+hw/rtl
hw/rtl/dmm_pkg.sv
hw/rtl/dmm_ram.sv
hw/rtl/dmm_ctrl.sv
hw/rtl/dmm_datapath.sv
hw/rtl/dense_matrix_multiply_top.sv
tb/sv/tb_dense_matrix_multiply_top.sv
